[rtl/accel_tilt_angles_defines.svh]
// ----------------------------------------------------------------------------
// accel_tilt_angles_defines
// assertion macros of the tilt angle rtl, used by accel_tilt_angles
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_DEFINES_SVH
`define ACCEL_TILT_ANGLES_DEFINES_SVH

// property that must hold in the same cycle
`define ATILT_ASSERT_NOW(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tilt check failed");

// consequent must hold in the cycle after the antecedent
`define ATILT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tilt check failed");

`endif

[rtl/atilt_pkg.sv]
// ----------------------------------------------------------------------------
// atilt_pkg
// types, widths and the arctangent table of the tilt angle pipeline
// ----------------------------------------------------------------------------
package atilt_pkg;

    localparam int SAMPLE_W = 16;                     // raw count width
    localparam int OUT_W    = 16;                     // angle width
    localparam int OUT_FRAC = 14;                     // angle fraction bits
    localparam int SQ_W     = 2 * SAMPLE_W + 1;       // sum of two squares
    localparam int SP       = SQ_W + (SQ_W % 2);      // radicand, even width
    localparam int SQRT_F   = 40;                     // root fraction bits
    localparam int NS       = SP / 2 + SQRT_F;        // root width and stages
    localparam int CW       = NS + 2;                 // cordic x/y width
    localparam int AF       = 52;                     // angle fraction bits
    localparam int ZW       = AF + 3;                 // angle accumulator
    localparam int N_IT     = 48;                     // cordic iterations

    localparam logic [OUT_W-1:0] HALF_PI_Q = 16'd25736;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic signed [OUT_W-1:0] pitch_angle;
        logic signed [OUT_W-1:0] roll_angle;
    } t_angles;

    typedef struct packed {
        logic valid;
        logic neg;     // numerator negative
        logic a_zero;  // numerator zero
        logic s_zero;  // denominator zero
    } t_ctl;

    // atan(2^-i) in AF fraction bits, worked out at elaboration
    function automatic logic [ZW-1:0] atan_q(input int i);
        real r;
        r = $atan(2.0 ** (-i)) * (2.0 ** AF);
        return ZW'(longint'(r));
    endfunction

endpackage

[rtl/atilt_prep.sv]
// ----------------------------------------------------------------------------
// atilt_prep
// magnitudes, squares and sums of squares, three register stages
// ----------------------------------------------------------------------------
module atilt_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  atilt_pkg::t_sample                i_sample,
    output logic [atilt_pkg::SAMPLE_W-1:0]    o_p_a,
    output logic [atilt_pkg::SQ_W-1:0]        o_p_s,
    output atilt_pkg::t_ctl                   o_p_ctl,
    output logic [atilt_pkg::SAMPLE_W-1:0]    o_r_a,
    output logic [atilt_pkg::SQ_W-1:0]        o_r_s,
    output atilt_pkg::t_ctl                   o_r_ctl
);

    localparam int W = atilt_pkg::SAMPLE_W;

    logic [W-1:0]      n_xm, n_ym, n_zm;
    atilt_pkg::t_ctl   n_p_ctl, n_r_ctl;
    logic [W-1:0]      r1_xm, r1_ym, r1_zm;
    atilt_pkg::t_ctl   r1_p_ctl, r1_r_ctl;
    logic [2*W-1:0]    r2_x2, r2_y2, r2_z2;
    logic [W-1:0]      r2_xm, r2_ym;
    atilt_pkg::t_ctl   r2_p_ctl, r2_r_ctl;
    logic [W-1:0]      r3_xm, r3_ym;
    logic [atilt_pkg::SQ_W-1:0] r3_p_s, r3_r_s;
    atilt_pkg::t_ctl   r3_p_ctl, r3_r_ctl;

    always_comb begin
        // the most negative count maps to 2^(W-1), still fits unsigned
        n_xm = i_sample.accel_x[W-1] ? (~i_sample.accel_x + 1'b1) : i_sample.accel_x;
        n_ym = i_sample.accel_y[W-1] ? (~i_sample.accel_y + 1'b1) : i_sample.accel_y;
        n_zm = i_sample.accel_z[W-1] ? (~i_sample.accel_z + 1'b1) : i_sample.accel_z;
        n_p_ctl.valid  = i_valid;
        n_p_ctl.neg    = ~i_sample.accel_x[W-1];
        n_p_ctl.a_zero = (n_xm == '0);
        n_p_ctl.s_zero = (n_ym == '0) && (n_zm == '0);
        n_r_ctl.valid  = i_valid;
        n_r_ctl.neg    = i_sample.accel_y[W-1];
        n_r_ctl.a_zero = (n_ym == '0);
        n_r_ctl.s_zero = (n_xm == '0) && (n_zm == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_p_ctl <= '0;
            r1_r_ctl <= '0;
            r2_p_ctl <= '0;
            r2_r_ctl <= '0;
            r3_p_ctl <= '0;
            r3_r_ctl <= '0;
        end else if (i_adv) begin
            r1_p_ctl <= n_p_ctl;
            r1_r_ctl <= n_r_ctl;
            r2_p_ctl <= r1_p_ctl;
            r2_r_ctl <= r1_r_ctl;
            r3_p_ctl <= r2_p_ctl;
            r3_r_ctl <= r2_r_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_xm  <= n_xm;
            r1_ym  <= n_ym;
            r1_zm  <= n_zm;
            r2_x2  <= r1_xm * r1_xm;
            r2_y2  <= r1_ym * r1_ym;
            r2_z2  <= r1_zm * r1_zm;
            r2_xm  <= r1_xm;
            r2_ym  <= r1_ym;
            r3_p_s <= atilt_pkg::SQ_W'(r2_y2) + atilt_pkg::SQ_W'(r2_z2);
            r3_r_s <= atilt_pkg::SQ_W'(r2_x2) + atilt_pkg::SQ_W'(r2_z2);
            r3_xm  <= r2_xm;
            r3_ym  <= r2_ym;
        end
    end

    assign o_p_a   = r3_xm;
    assign o_p_s   = r3_p_s;
    assign o_p_ctl = r3_p_ctl;
    assign o_r_a   = r3_ym;
    assign o_r_s   = r3_r_s;
    assign o_r_ctl = r3_r_ctl;

endmodule

[rtl/atilt_sqrt.sv]
// ----------------------------------------------------------------------------
// atilt_sqrt
// pipelined restoring square root, one root bit per stage
// ----------------------------------------------------------------------------
module atilt_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic [atilt_pkg::SQ_W-1:0]        i_s,
    input  logic [atilt_pkg::SAMPLE_W-1:0]    i_a,
    input  atilt_pkg::t_ctl                   i_ctl,
    output logic [atilt_pkg::NS-1:0]          o_root,
    output logic [atilt_pkg::SAMPLE_W-1:0]    o_a,
    output atilt_pkg::t_ctl                   o_ctl
);

    localparam int NS = atilt_pkg::NS;
    localparam int SP = atilt_pkg::SP;
    localparam int W  = atilt_pkg::SAMPLE_W;

    logic [NS+1:0]   r_rem  [0:NS-1];
    logic [NS-1:0]   r_root [0:NS-1];
    logic [SP-1:0]   r_s    [0:NS-1];
    logic [W-1:0]    r_a    [0:NS-1];
    atilt_pkg::t_ctl r_ctl  [0:NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [NS+1:0]   rem_in;
        logic [NS-1:0]   root_in;
        logic [SP-1:0]   s_in;
        logic [W-1:0]    a_in;
        atilt_pkg::t_ctl ctl_in;
        logic [1:0]      pair;
        logic [NS+1:0]   rem_sh, trial, n_rem;
        logic [NS-1:0]   n_root;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = SP'(i_s);
            assign a_in    = i_a;
            assign ctl_in  = i_ctl;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign s_in    = r_s[k-1];
            assign a_in    = r_a[k-1];
            assign ctl_in  = r_ctl[k-1];
        end

        // radicand bits first, then the zero fraction pairs
        if (k < SP / 2) begin : g_pair
            assign pair = s_in[SP-1-2*k -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        always_comb begin
            rem_sh = {rem_in[NS-1:0], pair};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {root_in[NS-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {root_in[NS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_adv) begin
                r_ctl[k] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_s[k]    <= s_in;
                r_a[k]    <= a_in;
            end
        end
    end

    assign o_root = r_root[NS-1];
    assign o_a    = r_a[NS-1];
    assign o_ctl  = r_ctl[NS-1];

endmodule

[rtl/atilt_cordic.sv]
// ----------------------------------------------------------------------------
// atilt_cordic
// pipelined vectoring cordic, one micro-rotation per stage
// ----------------------------------------------------------------------------
module atilt_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic [atilt_pkg::NS-1:0]          i_root,
    input  logic [atilt_pkg::SAMPLE_W-1:0]    i_a,
    input  atilt_pkg::t_ctl                   i_ctl,
    output logic signed [atilt_pkg::ZW-1:0]   o_z,
    output atilt_pkg::t_ctl                   o_ctl
);

    localparam int CW  = atilt_pkg::CW;
    localparam int ZW  = atilt_pkg::ZW;
    localparam int NIT = atilt_pkg::N_IT;
    localparam int FR  = atilt_pkg::SQRT_F;

    logic signed [CW-1:0] r_x   [0:NIT-1];
    logic signed [CW-1:0] r_y   [0:NIT-1];
    logic signed [ZW-1:0] r_z   [0:NIT-1];
    atilt_pkg::t_ctl      r_ctl [0:NIT-1];

    for (genvar i = 0; i < NIT; i++) begin : g_it
        localparam logic [ZW-1:0] ATAN_I = atilt_pkg::atan_q(i);
        logic signed [CW-1:0] x_in, y_in, n_x, n_y;
        logic signed [ZW-1:0] z_in, n_z;
        atilt_pkg::t_ctl      ctl_in;

        if (i == 0) begin : g_first
            // x is the root, y the numerator at the same scale
            assign x_in   = $signed(CW'(i_root));
            assign y_in   = $signed(CW'({i_a, {FR{1'b0}}}));
            assign z_in   = '0;
            assign ctl_in = i_ctl;
        end else begin : g_next
            assign x_in   = r_x[i-1];
            assign y_in   = r_y[i-1];
            assign z_in   = r_z[i-1];
            assign ctl_in = r_ctl[i-1];
        end

        always_comb begin
            if (!y_in[CW-1]) begin
                n_x = x_in + (y_in >>> i);
                n_y = y_in - (x_in >>> i);
                n_z = z_in + $signed(ATAN_I);
            end else begin
                n_x = x_in - (y_in >>> i);
                n_y = y_in + (x_in >>> i);
                n_z = z_in - $signed(ATAN_I);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[i] <= '0;
            end else if (i_adv) begin
                r_ctl[i] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_x[i] <= n_x;
                r_y[i] <= n_y;
                r_z[i] <= n_z;
            end
        end
    end

    assign o_z   = r_z[NIT-1];
    assign o_ctl = r_ctl[NIT-1];

endmodule

[rtl/accel_tilt_angles.sv]
// ----------------------------------------------------------------------------
// accel_tilt_angles
// pitch and roll tilt angles from one three-axis accelerometer sample
// input channel i_valid / o_stall carries i_sample (raw signed counts);
// output channel o_valid / i_stall carries o_angles, both angles in
// units of 2^-14 radian, rounded to nearest, within plus or minus pi/2
// one transaction in gives one transaction out, in order
// pipeline: 3 prep stages (magnitudes, squares, sums), 57 square
// root stages (one root bit each), 48 cordic stages, 1 rounding register
// throughput one sample per cycle while not stalled, set by the fully pipelined
// root and cordic; a receiver stall freezes every stage at once, so nothing is
// lost or repeated; o_stall follows a full output register that is stalled
// reset (synchronous, active low) clears all valid bits; data is kept
// ----------------------------------------------------------------------------
`include "accel_tilt_angles_defines.svh"

module accel_tilt_angles (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  atilt_pkg::t_sample   i_sample,
    output logic                 o_valid,
    input  logic                 i_stall,
    output atilt_pkg::t_angles   o_angles
);

    localparam int W  = atilt_pkg::SAMPLE_W;
    localparam int OW = atilt_pkg::OUT_W;
    localparam int ZW = atilt_pkg::ZW;
    localparam int AF = atilt_pkg::AF;
    localparam int OF = atilt_pkg::OUT_FRAC;

    // whole pipeline moves together unless the result register is held
    logic w_adv;

    logic [W-1:0]                  w_p_a, w_r_a, w_p_a2, w_r_a2;
    logic [atilt_pkg::SQ_W-1:0]    w_p_s, w_r_s;
    logic [atilt_pkg::NS-1:0]      w_p_root, w_r_root;
    logic signed [ZW-1:0]          w_p_z, w_r_z;
    atilt_pkg::t_ctl               w_p_ctl0, w_r_ctl0, w_p_ctl1, w_r_ctl1;
    atilt_pkg::t_ctl               w_p_ctl, w_r_ctl;

    atilt_pkg::t_angles            r_out, n_out;
    logic                          r_out_valid;

    // round half up to 2^-14 rad, then special cases and sign
    function automatic logic [OW-1:0] finish(input logic signed [ZW-1:0] z,
                                             input atilt_pkg::t_ctl c);
        logic [ZW-1:0] sum;
        logic [OW-1:0] mag;
        sum = $unsigned(z) + (ZW'(1) << (AF - OF - 1));
        mag = sum[AF-OF +: OW];
        if (c.a_zero) begin
            mag = '0;
        end else if (c.s_zero) begin
            mag = atilt_pkg::HALF_PI_Q;   // flat denominator, straight up or down
        end
        return c.neg ? (~mag + 1'b1) : mag;
    endfunction

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    atilt_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .o_p_a    (w_p_a),
        .o_p_s    (w_p_s),
        .o_p_ctl  (w_p_ctl0),
        .o_r_a    (w_r_a),
        .o_r_s    (w_r_s),
        .o_r_ctl  (w_r_ctl0)
    );

    // pitch lane: -x against sqrt(y^2 + z^2)
    atilt_sqrt u_p_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_s     (w_p_s),
        .i_a     (w_p_a),
        .i_ctl   (w_p_ctl0),
        .o_root  (w_p_root),
        .o_a     (w_p_a2),
        .o_ctl   (w_p_ctl1)
    );

    atilt_cordic u_p_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_root  (w_p_root),
        .i_a     (w_p_a2),
        .i_ctl   (w_p_ctl1),
        .o_z     (w_p_z),
        .o_ctl   (w_p_ctl)
    );

    // roll lane: y against sqrt(x^2 + z^2)
    atilt_sqrt u_r_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_s     (w_r_s),
        .i_a     (w_r_a),
        .i_ctl   (w_r_ctl0),
        .o_root  (w_r_root),
        .o_a     (w_r_a2),
        .o_ctl   (w_r_ctl1)
    );

    atilt_cordic u_r_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_root  (w_r_root),
        .i_a     (w_r_a2),
        .i_ctl   (w_r_ctl1),
        .o_z     (w_r_z),
        .o_ctl   (w_r_ctl)
    );

    always_comb begin
        n_out.pitch_angle = finish(w_p_z, w_p_ctl);
        n_out.roll_angle  = finish(w_r_z, w_r_ctl);
    end

    // both lanes run in lock step, the pitch valid stands for the pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_p_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_angles = r_out;

    `ATILT_ASSERT_NEXT(a_held_result, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_angles))
    `ATILT_ASSERT_NOW(a_pitch_range, i_clk, i_rst_n, !o_valid || ($signed(o_angles.pitch_angle) <= $signed(atilt_pkg::HALF_PI_Q) && $signed(o_angles.pitch_angle) >= -$signed(atilt_pkg::HALF_PI_Q)))
    `ATILT_ASSERT_NOW(a_roll_range, i_clk, i_rst_n, !o_valid || ($signed(o_angles.roll_angle) <= $signed(atilt_pkg::HALF_PI_Q) && $signed(o_angles.roll_angle) >= -$signed(atilt_pkg::HALF_PI_Q)))
    `ATILT_ASSERT_NEXT(a_zero_roll, i_clk, i_rst_n, w_adv && w_r_ctl.valid && w_r_ctl.a_zero, o_angles.roll_angle == '0)

endmodule
